FILE: hw/rtl/ibm_pkg.sv
`timescale 1ns / 1ps
// ibm_pkg: types, codes and micro program of the i2c bit-bang master
// no dependencies
package ibm_pkg;

	typedef struct packed {
		logic       op;
		logic [9:0] target_address;
		logic       ten_bit;
		logic       is_read;
		logic       skip_start;
		logic       skip_stop;
		logic       nack_ok;
		logic       no_read_ack;
		logic [7:0] write_data;
		logic       last_byte;
		logic       last_msg;
		logic [1:0] line_sample;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic [2:0] event_res;
		logic [7:0] read_data;
		logic [1:0] status;
		logic [7:0] messages_done;
	} res_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_ADDR_A, PH_GAP_A, PH_ADDR_B, PH_RESTART10,
		PH_ADDR_C, PH_GAP_C, PH_DATA_W, PH_DATA_R, PH_ACK, PH_STOP
	} phase_t;

	typedef enum logic [3:0] {
		U_END, U_SCL0, U_SDA0, U_SDA1, U_SDAB, U_SDAK, U_SHORT, U_LONG,
		U_WAIT, U_WAITI, U_RDBIT, U_ACKS, U_LOOP
	} uop_t;

	localparam logic       OP_CMD  = 1'b0;
	localparam logic       OP_TICK = 1'b1;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_ACCEPTED  = 3'd1;
	localparam logic [2:0] EV_BUSY      = 3'd2;
	localparam logic [2:0] EV_BYTE_DONE = 3'd3;
	localparam logic [2:0] EV_MSG_DONE  = 3'd4;
	localparam logic [2:0] EV_XFER_DONE = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_DISCARD = 2'd3;

	localparam logic [1:0] SR_OK      = 2'd0;
	localparam logic [1:0] SR_NACK    = 2'd1;
	localparam logic [1:0] SR_TIMEOUT = 2'd2;

	localparam logic [1:0] REG_HALF_BIT  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_RETRIES   = 2'd2;
	localparam logic [1:0] REG_STRETCH   = 2'd3;

	localparam logic [5:0] E_START   = 6'd0;
	localparam logic [5:0] E_RESTART = 6'd4;
	localparam logic [5:0] E_STOP    = 6'd11;
	localparam logic [5:0] E_GAP     = 6'd18;
	localparam logic [5:0] E_WRITE   = 6'd29;
	localparam logic [5:0] E_READ    = 6'd42;
	localparam logic [5:0] E_ACK     = 6'd50;

	localparam logic [7:0] TEN_BIT_HDR  = 8'hf0;
	localparam logic [2:0] TEN_BIT_MASK = 3'h6;

	function automatic uop_t prog(input logic [5:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = U_SDA0;  6'd1:  u = U_SHORT; 6'd2:  u = U_SCL0;  6'd3:  u = U_END;
			6'd4:  u = U_SDA1;  6'd5:  u = U_WAITI; 6'd6:  u = U_SHORT; 6'd7:  u = U_SDA0;
			6'd8:  u = U_SHORT; 6'd9:  u = U_SCL0;  6'd10: u = U_END;
			6'd11: u = U_SDA0;  6'd12: u = U_SHORT; 6'd13: u = U_WAITI; 6'd14: u = U_SHORT;
			6'd15: u = U_SDA1;  6'd16: u = U_LONG;  6'd17: u = U_END;
			6'd18: u = U_SDA0;  6'd19: u = U_SHORT; 6'd20: u = U_WAITI; 6'd21: u = U_SHORT;
			6'd22: u = U_SDA1;  6'd23: u = U_LONG;  6'd24: u = U_LONG;  6'd25: u = U_SDA0;
			6'd26: u = U_SHORT; 6'd27: u = U_SCL0;  6'd28: u = U_END;
			6'd29: u = U_SCL0;  6'd30: u = U_SDAB;  6'd31: u = U_SHORT; 6'd32: u = U_WAIT;
			6'd33: u = U_LOOP;
			6'd34: u = U_SCL0;  6'd35: u = U_SHORT; 6'd36: u = U_SDA1;  6'd37: u = U_SHORT;
			6'd38: u = U_WAIT;  6'd39: u = U_ACKS;  6'd40: u = U_SCL0;  6'd41: u = U_END;
			6'd42: u = U_SDA1;  6'd43: u = U_SHORT; 6'd44: u = U_WAIT;  6'd45: u = U_RDBIT;
			6'd46: u = U_SCL0;  6'd47: u = U_LONG;  6'd48: u = U_LOOP;  6'd49: u = U_END;
			6'd50: u = U_SDAK;  6'd51: u = U_SHORT; 6'd52: u = U_WAIT;  6'd53: u = U_SCL0;
			6'd54: u = U_END;
			default: u = U_END;
		endcase
		return u;
	endfunction

endpackage

FILE: hw/rtl/ibm_if.sv
`timescale 1ns / 1ps
// ibm_if: request, result and register write channels of the i2c master
// depends on ibm_pkg
interface ibm_item_if import ibm_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ibm_res_if import ibm_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ibm_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [15:0] wdata;
	modport source(output valid, output addr, output wdata, input ready);
	modport sink(input valid, input addr, input wdata, output ready);
endinterface

FILE: hw/rtl/ibm_front.sv
`timescale 1ns / 1ps
// ibm_front: two-entry request queue ahead of the bit engine
// depends on ibm_pkg, ibm_if
module ibm_front import ibm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ibm_item_if.sink     cmd,
	output queue_out_t   q_out,
	input  logic         pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign cmd.ready   = (count_q != 2'd2);
	assign push        = cmd.valid && cmd.ready;
	assign do_pop      = pop && (count_q != 2'd0);
	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/ibm_engine.sv
`timescale 1ns / 1ps
// ibm_engine: micro program bit engine, one step a cycle unless res
// stalls; register file, result register; depends on ibm_pkg, ibm_if
module ibm_engine import ibm_pkg::*; #(
	parameter int TIMEOUT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  queue_out_t q_in,
	output logic       pop,
	ibm_res_if.source  res,
	ibm_cfg_if.sink    cfg
);

	localparam int CW = (TIMEOUT_BITS > 16) ? TIMEOUT_BITS : 16;
	localparam logic [TIMEOUT_BITS-1:0] STRETCH_MAX = {TIMEOUT_BITS{1'b1}};

	typedef struct packed {
		logic [9:0] target_address;
		logic       ten_bit;
		logic       is_read;
		logic       skip_start;
		logic       skip_stop;
		logic       nack_ok;
		logic       no_read_ack;
		logic [7:0] write_data;
		logic       last_byte;
		logic       last_msg;
	} cmd_t;

	// registers
	logic [7:0]  half_bit_q;
	logic [15:0] timeout_q;
	logic [3:0]  retries_q;
	logic        stretch_en_q;

	phase_t      ph_q, ph_n;
	logic [5:0]  pc_q, pc_n;
	logic [2:0]  bc_q, bc_n;
	logic [7:0]  sb_q, sb_n;
	logic [7:0]  dc_q, dc_n;
	logic [TIMEOUT_BITS-1:0] sc_q, sc_n;
	logic [3:0]  rc_q, rc_n;
	logic        inm_q, inm_n;
	logic        ab_q, ab_n;
	logic        st_q, st_n;
	logic [7:0]  mc_q, mc_n;
	logic [1:0]  sr_q, sr_n;
	logic [1:0]  cs_q, cs_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        force_q, force_n;
	logic        busy_q, busy_n;
	cmd_t        pend_q, pend_n;
	logic [1:0]  smp_q, smp_n;
	logic [2:0]  ev_q, ev_n;
	logic [1:0]  evs_q, evs_n;
	logic [7:0]  evd_q, evd_n;
	logic [7:0]  evm_q, evm_n;

	logic        res_valid_q;
	res_t        res_q;

	logic        out_free;
	logic        active;
	logic        emit;
	res_t        res_n;
	logic [7:0]  short_ticks;
	logic [7:0]  fab;

	assign cfg.ready   = 1'b1;
	assign out_free    = !res_valid_q || res.ready;
	assign pop         = !busy_q && q_in.valid && out_free;
	assign active      = out_free && (busy_q || q_in.valid);
	assign res.valid   = res_valid_q;
	assign res.data    = res_q;

	always_comb begin
		logic [8:0] sum;
		sum         = {1'b0, half_bit_q} + 9'd1;
		short_ticks = sum[8:1];
		if (pend_q.ten_bit) begin
			fab = TEN_BIT_HDR | {5'd0, pend_q.target_address[9:7] & TEN_BIT_MASK};
		end else begin
			fab = {pend_q.target_address[6:0], pend_q.is_read};
		end
	end

	always_comb begin
		logic       go_loop;
		logic       ex;
		logic       do_seq;
		logic       f_abort;
		logic [1:0] ab_st;
		logic       f_complete;
		logic       f_begin;
		logic       f_enter;
		logic       f_wr;
		logic       f_end;
		phase_t     en_ph;
		logic [5:0] en_pc;
		logic [7:0] wr_val;
		logic [7:0] d;
		logic [3:0] limit;
		logic       second;
		logic [TIMEOUT_BITS-1:0] sc_inc;
		logic [CW-1:0] inc_w;
		logic [CW-1:0] to_w;
		item_t      it;

		ph_n = ph_q; pc_n = pc_q; bc_n = bc_q; sb_n = sb_q; dc_n = dc_q;
		sc_n = sc_q; rc_n = rc_q; inm_n = inm_q; ab_n = ab_q; st_n = st_q;
		mc_n = mc_q; sr_n = sr_q; cs_n = cs_q; scl_n = scl_q; sda_n = sda_q;
		force_n = force_q; busy_n = busy_q; pend_n = pend_q; smp_n = smp_q;
		ev_n = ev_q; evs_n = evs_q; evd_n = evd_q; evm_n = evm_q;
		go_loop = 1'b0; ex = 1'b0; do_seq = 1'b0;
		f_abort = 1'b0; ab_st = ST_OK; f_complete = 1'b0; f_begin = 1'b0;
		f_enter = 1'b0; f_wr = 1'b0; f_end = 1'b0;
		en_ph = PH_IDLE; en_pc = E_START; wr_val = 8'd0; d = 8'd0;
		limit = 4'd0; second = 1'b0;
		it = q_in.item;
		sc_inc = (sc_q != STRETCH_MAX) ? sc_q + 1'b1 : sc_q;
		inc_w = CW'(sc_inc);
		to_w  = CW'(timeout_q);

		if (!busy_q) begin
			ev_n = EV_NONE; evs_n = ST_OK; evd_n = 8'd0; evm_n = 8'd0;
			smp_n = it.line_sample;
			if (it.op == OP_CMD) begin
				if (ph_q != PH_IDLE) begin
					ev_n = EV_BUSY;
				end else if (ab_q) begin
					ev_n = EV_ACCEPTED;
					evs_n = ST_DISCARD;
					if (it.last_byte && it.last_msg) begin
						ab_n = 1'b0;
					end
				end else begin
					pend_n = '{it.target_address, it.ten_bit, it.is_read, it.skip_start,
						it.skip_stop, it.nack_ok, it.no_read_ack, it.write_data,
						it.last_byte, it.last_msg};
					cs_n = ST_OK; st_n = 1'b0; dc_n = 8'd0;
					ev_n = EV_ACCEPTED;
					if (!inm_q && !it.skip_start) begin
						f_enter = 1'b1;
						en_ph = PH_START;
						en_pc = (mc_q == 8'd0) ? E_START : E_RESTART;
					end else begin
						f_begin = 1'b1;
					end
				end
			end else if (ph_q == PH_IDLE) begin
				ev_n = EV_NONE;
			end else if (dc_q != 8'd0) begin
				dc_n = dc_q - 8'd1;
			end else if (st_q) begin
				if (it.line_sample[1]) begin
					st_n = 1'b0;
					pc_n = pc_q + 6'd1;
					if (short_ticks != 8'd0) begin
						dc_n = short_ticks - 8'd1;
					end else begin
						go_loop = 1'b1;
					end
				end else begin
					sc_n = sc_inc;
					if (inc_w > to_w || sc_inc == STRETCH_MAX) begin
						st_n = 1'b0;
						go_loop = 1'b1;
						if (prog(pc_q) == U_WAITI) begin
							pc_n = pc_q + 6'd1;
						end else begin
							sr_n = SR_TIMEOUT;
							force_n = 1'b1;
						end
					end
				end
			end else begin
				go_loop = 1'b1;
			end
		end else begin
			if (force_q) begin
				force_n = 1'b0;
				do_seq = 1'b1;
			end else begin
				case (prog(pc_q))
					U_SCL0: begin scl_n = 1'b0; pc_n = pc_q + 6'd1; end
					U_SDA0: begin sda_n = 1'b0; pc_n = pc_q + 6'd1; end
					U_SDA1: begin sda_n = 1'b1; pc_n = pc_q + 6'd1; end
					U_SDAB: begin sda_n = sb_q[3'd7 - bc_q]; pc_n = pc_q + 6'd1; end
					U_SDAK: begin
						if (!pend_q.last_byte) begin
							sda_n = 1'b0;
						end
						pc_n = pc_q + 6'd1;
					end
					U_SHORT, U_LONG: begin
						d = (prog(pc_q) == U_SHORT) ? short_ticks : half_bit_q;
						pc_n = pc_q + 6'd1;
						if (d != 8'd0) begin
							dc_n = d - 8'd1;
							ex = 1'b1;
						end
					end
					U_WAIT, U_WAITI: begin
						scl_n = 1'b1;
						if (stretch_en_q) begin
							st_n = 1'b1;
							sc_n = '0;
							ex = 1'b1;
						end else begin
							pc_n = pc_q + 6'd1;
							if (short_ticks != 8'd0) begin
								dc_n = short_ticks - 8'd1;
								ex = 1'b1;
							end
						end
					end
					U_RDBIT: begin sb_n = {sb_q[6:0], smp_q[0]}; pc_n = pc_q + 6'd1; end
					U_ACKS: begin
						sr_n = smp_q[0] ? SR_NACK : SR_OK;
						pc_n = pc_q + 6'd1;
					end
					U_LOOP: begin
						if (bc_q != 3'd7) begin
							bc_n = bc_q + 3'd1;
							pc_n = pc_q - 6'd4;
						end else begin
							bc_n = 3'd0;
							pc_n = pc_q + 6'd1;
						end
					end
					default: do_seq = 1'b1;
				endcase
			end
		end

		if (do_seq) begin
			second = (ph_q == PH_ADDR_C);
			limit = pend_q.nack_ok ? 4'd0 : retries_q;
			case (ph_q)
				PH_START: begin
					rc_n = 4'd0;
					f_enter = 1'b1; f_wr = 1'b1; en_ph = PH_ADDR_A; wr_val = fab;
				end
				PH_ADDR_A, PH_ADDR_C: begin
					if (sr_q != SR_OK && rc_q < limit) begin
						rc_n = rc_q + 4'd1;
						f_enter = 1'b1; en_pc = E_GAP;
						en_ph = second ? PH_GAP_C : PH_GAP_A;
					end else if (sr_q == SR_TIMEOUT) begin
						f_abort = 1'b1; ab_st = ST_TIMEOUT;
					end else if (sr_q == SR_NACK && !pend_q.nack_ok) begin
						f_abort = 1'b1; ab_st = ST_NACK;
					end else begin
						if (sr_q == SR_NACK) begin
							cs_n = ST_NACK;
						end
						if (!second && pend_q.ten_bit) begin
							f_enter = 1'b1; f_wr = 1'b1; en_ph = PH_ADDR_B;
							wr_val = pend_q.target_address[7:0];
						end else begin
							f_begin = 1'b1;
						end
					end
				end
				PH_GAP_A: begin
					f_enter = 1'b1; f_wr = 1'b1; en_ph = PH_ADDR_A; wr_val = fab;
				end
				PH_GAP_C, PH_RESTART10: begin
					if (ph_q == PH_RESTART10) begin
						rc_n = 4'd0;
					end
					f_enter = 1'b1; f_wr = 1'b1; en_ph = PH_ADDR_C; wr_val = fab | 8'h01;
				end
				PH_ADDR_B, PH_DATA_W: begin
					if (sr_q == SR_TIMEOUT) begin
						f_abort = 1'b1; ab_st = ST_TIMEOUT;
					end else if (sr_q == SR_NACK && !pend_q.nack_ok) begin
						f_abort = 1'b1; ab_st = ST_NACK;
					end else begin
						if (sr_q == SR_NACK) begin
							cs_n = ST_NACK;
						end
						if (ph_q == PH_DATA_W) begin
							f_complete = 1'b1;
						end else if (pend_q.is_read) begin
							f_enter = 1'b1; en_ph = PH_RESTART10; en_pc = E_RESTART;
						end else begin
							f_begin = 1'b1;
						end
					end
				end
				PH_DATA_R: begin
					if (sr_q == SR_TIMEOUT) begin
						f_abort = 1'b1; ab_st = ST_TIMEOUT;
					end else if (!pend_q.no_read_ack) begin
						f_enter = 1'b1; en_ph = PH_ACK; en_pc = E_ACK;
					end else begin
						f_complete = 1'b1;
					end
				end
				PH_ACK: begin
					if (sr_q == SR_TIMEOUT) begin
						f_abort = 1'b1; ab_st = ST_TIMEOUT;
					end else begin
						f_complete = 1'b1;
					end
				end
				PH_STOP: f_end = 1'b1;
				default: ph_n = PH_IDLE;
			endcase
		end

		if (f_wr) begin
			en_pc = E_WRITE;
		end
		if (f_abort) begin
			ab_n = 1'b1;
			cs_n = ab_st;
			if (!pend_q.skip_stop) begin
				f_enter = 1'b1; en_ph = PH_STOP; en_pc = E_STOP;
			end else begin
				f_end = 1'b1;
			end
		end
		if (f_complete) begin
			if (pend_q.last_byte) begin
				inm_n = 1'b0;
				if (mc_n != 8'hff) begin
					mc_n = mc_n + 8'd1;
				end
			end else begin
				inm_n = 1'b1;
			end
			if (pend_q.last_byte && pend_q.last_msg) begin
				if (!pend_q.skip_stop) begin
					f_enter = 1'b1; en_ph = PH_STOP; en_pc = E_STOP;
				end else begin
					f_end = 1'b1;
				end
			end else begin
				ev_n = pend_q.last_byte ? EV_MSG_DONE : EV_BYTE_DONE;
				evs_n = cs_n;
				evd_n = pend_q.is_read ? sb_n : 8'd0;
				ph_n = PH_IDLE;
			end
		end
		if (f_begin) begin
			f_enter = 1'b1;
			if (pend_n.is_read) begin
				en_ph = PH_DATA_R; en_pc = E_READ;
				sb_n = 8'd0;
			end else begin
				en_ph = PH_DATA_W; en_pc = E_WRITE;
				f_wr = 1'b1; wr_val = pend_n.write_data;
			end
		end
		if (f_enter) begin
			ph_n = en_ph; pc_n = en_pc; sr_n = SR_OK; bc_n = 3'd0;
			if (f_wr) begin
				sb_n = wr_val;
			end
		end
		if (f_end) begin
			ev_n = EV_XFER_DONE;
			evs_n = cs_n;
			evm_n = mc_n;
			evd_n = (pend_q.is_read && !ab_n) ? sb_n : 8'd0;
			mc_n = 8'd0;
			inm_n = 1'b0;
			if (pend_q.last_byte && pend_q.last_msg) begin
				ab_n = 1'b0;
			end
			ph_n = PH_IDLE;
		end

		if (busy_q) begin
			ex = ex || (ph_n == PH_IDLE);
			emit = ex;
			busy_n = !ex;
		end else begin
			emit = !go_loop;
			busy_n = go_loop;
		end

		res_n.scl_out = scl_n;
		res_n.sda_out = sda_n;
		res_n.event_res = ev_n;
		res_n.read_data = evd_n;
		res_n.status = evs_n;
		res_n.messages_done = (ev_n == EV_XFER_DONE) ? evm_n : mc_n;
	end

	always_ff @(posedge clk) begin
		if (active && emit) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= 8'd5;
			timeout_q <= 16'd1000;
			retries_q <= 4'd0;
			stretch_en_q <= 1'b1;
			ph_q <= PH_IDLE; pc_q <= 6'd0; bc_q <= 3'd0; sb_q <= 8'd0; dc_q <= 8'd0;
			sc_q <= '0; rc_q <= 4'd0; inm_q <= 1'b0; ab_q <= 1'b0; st_q <= 1'b0;
			mc_q <= 8'd0; sr_q <= SR_OK; cs_q <= ST_OK; scl_q <= 1'b1; sda_q <= 1'b1;
			force_q <= 1'b0; busy_q <= 1'b0; pend_q <= '0; smp_q <= 2'd0;
			ev_q <= EV_NONE; evs_q <= ST_OK; evd_q <= 8'd0; evm_q <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.addr)
					REG_HALF_BIT: half_bit_q <= cfg.wdata[7:0];
					REG_TIMEOUT:  timeout_q <= cfg.wdata;
					REG_RETRIES:  retries_q <= cfg.wdata[3:0];
					REG_STRETCH:  stretch_en_q <= cfg.wdata[0];
					default:      half_bit_q <= half_bit_q;
				endcase
			end
			if (active) begin
				ph_q <= ph_n; pc_q <= pc_n; bc_q <= bc_n; sb_q <= sb_n; dc_q <= dc_n;
				sc_q <= sc_n; rc_q <= rc_n; inm_q <= inm_n; ab_q <= ab_n; st_q <= st_n;
				mc_q <= mc_n; sr_q <= sr_n; cs_q <= cs_n; scl_q <= scl_n; sda_q <= sda_n;
				force_q <= force_n; busy_q <= busy_n; pend_q <= pend_n; smp_q <= smp_n;
				ev_q <= ev_n; evs_q <= evs_n; evd_q <= evd_n; evm_q <= evm_n;
			end
			if (active && emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/i2c_bitbang_master.sv
`timescale 1ns / 1ps
// i2c_bitbang_master: top level, request queue feeding the bit engine
// depends on ibm_pkg, ibm_if, ibm_front, ibm_engine
//
// cmd carries byte commands (op 0) and time ticks with sampled SDA/SCL
// (op 1); every request gives exactly one result on res with the SCL and
// SDA drives, an event code, read data, status and message count.
// cfg writes the four registers; it is always ready.
// A request goes through a two-entry queue into the bit engine. A command,
// an idle tick or a tick that only counts down a delay or a stretch wait
// needs no micro step, so such requests flow at one per cycle while res
// does not stall. A tick that runs the micro program keeps the engine busy
// through its micro steps; the engine pops no new request until they are done.
// A request with no micro step, through an empty queue, passes the queue
// entry and then the result register before its result is valid on res.
// The result register holds one result; when res stalls the engine stops
// and the queue fills, then cmd.ready drops.
// Reset releases both lines, returns the engine to idle and loads the
// register defaults.
module i2c_bitbang_master import ibm_pkg::*; #(
	parameter int TIMEOUT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	ibm_item_if.sink  cmd,
	ibm_res_if.source res,
	ibm_cfg_if.sink   cfg
);

	queue_out_t q_out;
	logic       pop;

	ibm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_out  (q_out),
		.pop    (pop)
	);

	ibm_engine #(
		.TIMEOUT_BITS (TIMEOUT_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.q_in   (q_out),
		.pop    (pop),
		.res    (res),
		.cfg    (cfg)
	);

endmodule

FILE: sim/i2c_bitbang_master_test.sv
`timescale 1ns / 1ps
// i2c_bitbang_master_test: self-checking bench for the i2c bit-bang master
// keeps its own model of the bit engine and checks every result against it
// depends on ibm_pkg, ibm_if and the i2c_bitbang_master rtl
module i2c_bitbang_master_test;
	import ibm_pkg::*;

	localparam int STRETCH_MAX = 65535;
	localparam int UC_LEN = 55;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1600;
	localparam int MIN_RANDOM_ITEMS = 400;

	localparam uop_t UCODE [0:54] = '{
		U_SDA0, U_SHORT, U_SCL0, U_END,
		U_SDA1, U_WAITI, U_SHORT, U_SDA0, U_SHORT, U_SCL0, U_END,
		U_SDA0, U_SHORT, U_WAITI, U_SHORT, U_SDA1, U_LONG, U_END,
		U_SDA0, U_SHORT, U_WAITI, U_SHORT, U_SDA1, U_LONG, U_LONG,
		U_SDA0, U_SHORT, U_SCL0, U_END,
		U_SCL0, U_SDAB, U_SHORT, U_WAIT, U_LOOP,
		U_SCL0, U_SHORT, U_SDA1, U_SHORT, U_WAIT, U_ACKS, U_SCL0, U_END,
		U_SDA1, U_SHORT, U_WAIT, U_RDBIT, U_SCL0, U_LONG, U_LOOP, U_END,
		U_SDAK, U_SHORT, U_WAIT, U_SCL0, U_END
	};

	logic clk;
	logic arst_n;

	ibm_item_if cmd ();
	ibm_res_if  res ();
	ibm_cfg_if  cfg ();

	i2c_bitbang_master dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	// engine model state
	logic [7:0]  half_bit;
	logic [15:0] timeout_reg;
	logic [3:0]  retries_reg;
	logic        stretch_en;
	phase_t      phase;
	int          bit_cnt;
	logic [7:0]  shift_byte;
	logic [7:0]  delay_cnt;
	int          str_cnt;
	int          retry_cnt;
	item_t       pend;
	bit          bus_held, in_message, aborting, stretching;
	int          msg_cnt;
	int          pc;
	logic [1:0]  seq_result, cmd_status;
	logic        scl_drv, sda_drv;
	logic [2:0]  ev;
	logic [1:0]  ev_status;
	logic [7:0]  ev_data, ev_msgs;

	res_t expected_results [$];
	int   errors;
	int   cycles;
	int   items_sent;
	bit   gaps_on;
	int   long_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int short_ticks();
		return (int'(half_bit) + 1) >> 1;
	endfunction

	function void enter(phase_t ph, int entry);
		phase = ph;
		pc = entry;
		seq_result = SR_OK;
		bit_cnt = 0;
	endfunction

	function void enter_write(phase_t ph, logic [7:0] v);
		enter(ph, int'(E_WRITE));
		shift_byte = v;
	endfunction

	function logic [7:0] first_addr_byte();
		if (pend.ten_bit)
			return TEN_BIT_HDR | {5'd0, pend.target_address[9:7] & TEN_BIT_MASK};
		return {pend.target_address[6:0], pend.is_read};
	endfunction

	function void begin_data();
		if (pend.is_read) begin
			enter(PH_DATA_R, int'(E_READ));
			shift_byte = 8'd0;
		end else begin
			enter_write(PH_DATA_W, pend.write_data);
		end
	endfunction

	function void end_transfer();
		ev = EV_XFER_DONE;
		ev_status = cmd_status;
		ev_msgs = msg_cnt[7:0];
		ev_data = (pend.is_read && !aborting) ? shift_byte : 8'd0;
		msg_cnt = 0;
		in_message = 0;
		if (pend.last_byte && pend.last_msg)
			aborting = 0;
		phase = PH_IDLE;
	endfunction

	function void abort_transfer(logic [1:0] st);
		aborting = 1;
		cmd_status = st;
		if (!pend.skip_stop)
			enter(PH_STOP, int'(E_STOP));
		else
			end_transfer();
	endfunction

	function bit outcome_ok();
		if (seq_result == SR_TIMEOUT) begin
			abort_transfer(ST_TIMEOUT);
			return 0;
		end
		if (seq_result == SR_NACK) begin
			if (!pend.nack_ok) begin
				abort_transfer(ST_NACK);
				return 0;
			end
			cmd_status = ST_NACK;
		end
		return 1;
	endfunction

	function void complete_byte();
		if (pend.last_byte) begin
			in_message = 0;
			if (msg_cnt < 255)
				msg_cnt++;
		end else begin
			in_message = 1;
		end
		if (pend.last_byte && pend.last_msg) begin
			if (!pend.skip_stop)
				enter(PH_STOP, int'(E_STOP));
			else
				end_transfer();
			return;
		end
		ev = pend.last_byte ? EV_MSG_DONE : EV_BYTE_DONE;
		ev_status = cmd_status;
		ev_data = pend.is_read ? shift_byte : 8'd0;
		phase = PH_IDLE;
	endfunction

	function void address_done(bit second);
		int lim;
		lim = pend.nack_ok ? 0 : int'(retries_reg);
		if (seq_result != SR_OK && retry_cnt < lim) begin
			retry_cnt++;
			enter(second ? PH_GAP_C : PH_GAP_A, int'(E_GAP));
			return;
		end
		if (seq_result == SR_TIMEOUT) begin
			abort_transfer(ST_TIMEOUT);
			return;
		end
		if (!outcome_ok())
			return;
		if (!second && pend.ten_bit)
			enter_write(PH_ADDR_B, pend.target_address[7:0]);
		else
			begin_data();
	endfunction

	function void seq_done();
		case (phase)
			PH_START: begin
				bus_held = 1;
				retry_cnt = 0;
				enter_write(PH_ADDR_A, first_addr_byte());
			end
			PH_ADDR_A: address_done(0);
			PH_ADDR_C: address_done(1);
			PH_GAP_A: enter_write(PH_ADDR_A, first_addr_byte());
			PH_GAP_C: enter_write(PH_ADDR_C, first_addr_byte() | 8'h01);
			PH_ADDR_B: begin
				if (outcome_ok()) begin
					if (pend.is_read)
						enter(PH_RESTART10, int'(E_RESTART));
					else
						begin_data();
				end
			end
			PH_RESTART10: begin
				retry_cnt = 0;
				enter_write(PH_ADDR_C, first_addr_byte() | 8'h01);
			end
			PH_DATA_W: begin
				if (outcome_ok())
					complete_byte();
			end
			PH_DATA_R: begin
				if (seq_result == SR_TIMEOUT)
					abort_transfer(ST_TIMEOUT);
				else if (!pend.no_read_ack)
					enter(PH_ACK, int'(E_ACK));
				else
					complete_byte();
			end
			PH_ACK: begin
				if (seq_result == SR_TIMEOUT)
					abort_transfer(ST_TIMEOUT);
				else
					complete_byte();
			end
			PH_STOP: begin
				bus_held = 0;
				end_transfer();
			end
			default: phase = PH_IDLE;
		endcase
	endfunction

	function void run_tick(logic [1:0] s);
		int d;
		if (phase == PH_IDLE)
			return;
		if (delay_cnt != 0) begin
			delay_cnt--;
			return;
		end
		if (stretching) begin
			if (s[1]) begin
				stretching = 0;
				pc++;
				d = short_ticks();
				if (d != 0) begin
					delay_cnt = 8'(d - 1);
					return;
				end
			end else begin
				if (str_cnt < STRETCH_MAX)
					str_cnt++;
				if (str_cnt > int'(timeout_reg) || str_cnt >= STRETCH_MAX) begin
					stretching = 0;
					if (UCODE[pc % UC_LEN] == U_WAITI) begin
						pc++;
					end else begin
						seq_result = SR_TIMEOUT;
						seq_done();
					end
				end else begin
					return;
				end
			end
		end
		while (phase != PH_IDLE) begin
			pc = pc % UC_LEN;
			case (UCODE[pc])
				U_SCL0: begin scl_drv = 0; pc++; end
				U_SDA0: begin sda_drv = 0; pc++; end
				U_SDA1: begin sda_drv = 1; pc++; end
				U_SDAB: begin sda_drv = shift_byte[7 - (bit_cnt & 7)]; pc++; end
				U_SDAK: begin
					if (!pend.last_byte)
						sda_drv = 0;
					pc++;
				end
				U_SHORT, U_LONG: begin
					d = (UCODE[pc] == U_SHORT) ? short_ticks() : int'(half_bit);
					pc++;
					if (d != 0) begin
						delay_cnt = 8'(d - 1);
						return;
					end
				end
				U_WAIT, U_WAITI: begin
					scl_drv = 1;
					if (stretch_en) begin
						stretching = 1;
						str_cnt = 0;
						return;
					end
					pc++;
					d = short_ticks();
					if (d != 0) begin
						delay_cnt = 8'(d - 1);
						return;
					end
				end
				U_RDBIT: begin shift_byte = {shift_byte[6:0], s[0]}; pc++; end
				U_ACKS: begin seq_result = s[0] ? SR_NACK : SR_OK; pc++; end
				U_LOOP: begin
					if (bit_cnt < 7) begin
						bit_cnt++;
						pc -= 4;
					end else begin
						bit_cnt = 0;
						pc++;
					end
				end
				default: seq_done();
			endcase
		end
	endfunction

	function void predict_result(item_t it);
		res_t r;
		ev = EV_NONE;
		ev_status = ST_OK;
		ev_data = 8'd0;
		ev_msgs = 8'd0;
		if (it.op == OP_CMD) begin
			if (phase != PH_IDLE) begin
				ev = EV_BUSY;
			end else if (aborting) begin
				ev = EV_ACCEPTED;
				ev_status = ST_DISCARD;
				if (it.last_byte && it.last_msg)
					aborting = 0;
			end else begin
				pend = it;
				cmd_status = ST_OK;
				stretching = 0;
				delay_cnt = 0;
				ev = EV_ACCEPTED;
				if (!in_message && !pend.skip_start)
					enter(PH_START, msg_cnt == 0 ? int'(E_START) : int'(E_RESTART));
				else
					begin_data();
			end
		end else begin
			run_tick(it.line_sample);
		end
		if (ev != EV_XFER_DONE)
			ev_msgs = msg_cnt[7:0];
		r.scl_out = scl_drv;
		r.sda_out = sda_drv;
		r.event_res = ev;
		r.read_data = ev_data;
		r.status = ev_status;
		r.messages_done = ev_msgs;
		expected_results.push_back(r);
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 12);
		if (gap != 0) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd.valid <= 1'b1;
		cmd.data <= it;
		do @(posedge clk); while (!cmd.ready);
		predict_result(it);
		items_sent++;
	endtask

	task automatic release_cmd();
		@(negedge clk);
		cmd.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_cmd();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_HALF_BIT: half_bit = val[7:0];
			REG_TIMEOUT:  timeout_reg = val;
			REG_RETRIES:  retries_reg = val[3:0];
			default:      stretch_en = val[0];
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_regs(int hb, int tmo, int rt, int se);
		write_reg(REG_HALF_BIT, 16'(hb));
		write_reg(REG_TIMEOUT, 16'(tmo));
		write_reg(REG_RETRIES, 16'(rt));
		write_reg(REG_STRETCH, 16'(se));
	endtask

	function automatic item_t tick_item(int sda_lo, int scl_lo);
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.op = OP_TICK;
		it.line_sample[0] = $urandom_range(0, 99) >= sda_lo;
		it.line_sample[1] = $urandom_range(0, 99) >= scl_lo;
		return it;
	endfunction

	function automatic item_t byte_cmd(bit rd, bit tb, bit lb, bit lm);
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.op = OP_CMD;
		it.is_read = rd;
		it.ten_bit = tb;
		it.last_byte = lb;
		it.last_msg = lm;
		it.skip_start = 0;
		it.skip_stop = 0;
		it.nack_ok = 0;
		it.no_read_ack = 0;
		return it;
	endfunction

	// ticks until the engine goes back to idle or cap ticks are sent
	task automatic run_bus(int sda_lo, int scl_lo, int cap);
		int n;
		n = 0;
		while (phase != PH_IDLE && n < cap) begin
			send_item(tick_item(sda_lo, scl_lo));
			n++;
		end
	endtask

	task automatic send_byte(item_t it, int sda_lo, int scl_lo);
		send_item(it);
		run_bus(sda_lo, scl_lo, 4000);
	endtask

	task automatic test_basic_messages();
		item_t it;
		set_regs(1, 1000, 0, 1);
		send_byte(byte_cmd(0, 0, 0, 0), 0, 0);
		send_byte(byte_cmd(0, 0, 1, 0), 0, 0);
		it = byte_cmd(1, 0, 0, 1);
		send_byte(it, 0, 0);
		it = byte_cmd(1, 0, 1, 1);
		it.no_read_ack = 1;
		send_byte(it, 0, 0);
		send_byte(byte_cmd(0, 1, 1, 0), 0, 5);
		send_byte(byte_cmd(1, 1, 1, 1), 0, 5);
		it = byte_cmd(0, 0, 1, 1);
		it.skip_start = 1;
		it.skip_stop = 1;
		it.write_data = 8'hff;
		send_byte(it, 0, 0);
	endtask

	task automatic test_busy_reject();
		send_item(byte_cmd(0, 0, 1, 1));
		send_item(byte_cmd(1, 0, 1, 1));
		send_item(tick_item(0, 0));
		send_item(byte_cmd(0, 1, 0, 0));
		run_bus(0, 0, 4000);
	endtask

	task automatic test_nack_paths();
		item_t it;
		set_regs(0, 1000, 2, 0);
		send_byte(byte_cmd(0, 0, 1, 1), 100, 0);
		it = byte_cmd(0, 0, 1, 1);
		it.nack_ok = 1;
		send_byte(it, 100, 0);
		set_regs(2, 1000, 15, 1);
		send_byte(byte_cmd(1, 1, 1, 1), 60, 0);
		send_byte(byte_cmd(0, 0, 0, 0), 100, 0);
		send_byte(byte_cmd(0, 0, 1, 0), 0, 0);
		send_byte(byte_cmd(0, 0, 1, 1), 0, 0);
	endtask

	task automatic test_stretch_timeout();
		item_t it;
		set_regs(1, 0, 0, 1);
		send_byte(byte_cmd(0, 0, 1, 1), 0, 100);
		set_regs(1, 3, 1, 1);
		it = byte_cmd(0, 1, 0, 0);
		it.nack_ok = 1;
		it.skip_stop = 1;
		send_byte(it, 0, 100);
		send_byte(byte_cmd(0, 0, 1, 1), 0, 0);
		set_regs(0, 65535, 0, 1);
		send_byte(byte_cmd(1, 0, 1, 1), 0, 20);
	endtask

	task automatic test_slow_bit_rate();
		item_t it;
		set_regs(31, 65535, 0, 0);
		it = byte_cmd(0, 0, 1, 1);
		it.skip_start = 1;
		it.write_data = 8'h00;
		send_byte(it, 0, 0);
	endtask

	task automatic test_result_backpressure();
		set_regs(3, 1000, 0, 1);
		send_item(byte_cmd(1, 0, 1, 1));
		long_hold = 400;
		repeat (120) send_item(tick_item(30, 0));
		run_bus(30, 0, 4000);
	endtask

	task automatic random_transfer();
		item_t it;
		int nmsg, nby;
		bit tb, rd;
		nmsg = $urandom_range(1, 3);
		for (int m = 0; m < nmsg; m++) begin
			nby = $urandom_range(1, 3);
			tb = $urandom_range(0, 3) == 0;
			rd = 1'($urandom_range(0, 1));
			for (int b = 0; b < nby; b++) begin
				it = byte_cmd(rd, tb, b == nby - 1, m == nmsg - 1 && b == nby - 1);
				it.skip_start = $urandom_range(0, 9) == 0;
				it.skip_stop = $urandom_range(0, 6) == 0;
				it.nack_ok = $urandom_range(0, 3) == 0;
				it.no_read_ack = $urandom_range(0, 4) == 0;
				if ($urandom_range(0, 9) == 0) begin
					it = item_t'({$urandom, $urandom});
					it.op = OP_CMD;
				end
				send_item(it);
				if ($urandom_range(0, 5) == 0)
					send_item(byte_cmd(1'($urandom), 1'($urandom), 1'($urandom),
						1'($urandom)));
				run_bus($urandom_range(0, 1) ? 10 : 50, $urandom_range(0, 2) ? 0 : 15, 3000);
				if ($urandom_range(0, 7) == 0)
					send_item(tick_item(50, 50));
			end
		end
	endtask

	task automatic test_random_traffic();
		int start;
		start = items_sent;
		while (items_sent < ITEM_TARGET || items_sent - start < MIN_RANDOM_ITEMS) begin
			if (items_sent >= ITEM_TARGET * 4 / 5 &&
				items_sent - start >= MIN_RANDOM_ITEMS * 4 / 5)
				gaps_on = 0;
			if ($urandom_range(0, 2) == 0)
				set_regs($urandom_range(0, 4), $urandom_range(0, 1) ? 1000 : $urandom_range(0, 40),
					$urandom_range(0, 3), $urandom_range(0, 1));
			random_transfer();
		end
	endtask

	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				long_hold--;
				res.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", res.data);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (res.data.scl_out !== want.scl_out) begin
					$error("scl_out expected %h actual %h", want.scl_out, res.data.scl_out);
					errors++;
				end
				if (res.data.sda_out !== want.sda_out) begin
					$error("sda_out expected %h actual %h", want.sda_out, res.data.sda_out);
					errors++;
				end
				if (res.data.event_res !== want.event_res) begin
					$error("event_res expected %h actual %h", want.event_res, res.data.event_res);
					errors++;
				end
				if (res.data.read_data !== want.read_data) begin
					$error("read_data expected %h actual %h", want.read_data, res.data.read_data);
					errors++;
				end
				if (res.data.status !== want.status) begin
					$error("status expected %h actual %h", want.status, res.data.status);
					errors++;
				end
				if (res.data.messages_done !== want.messages_done) begin
					$error("messages_done expected %h actual %h", want.messages_done,
						res.data.messages_done);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** i2c_bitbang_master: FAILED **");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		items_sent = 0;
		gaps_on = 1;
		long_hold = 0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.data = '0;
		cfg.valid = 1'b0;
		cfg.addr = REG_HALF_BIT;
		cfg.wdata = '0;
		half_bit = 8'd5;
		timeout_reg = 16'd1000;
		retries_reg = 4'd0;
		stretch_en = 1'b1;
		phase = PH_IDLE;
		bit_cnt = 0;
		shift_byte = 8'd0;
		delay_cnt = 8'd0;
		str_cnt = 0;
		retry_cnt = 0;
		pend = '0;
		bus_held = 0;
		in_message = 0;
		aborting = 0;
		stretching = 0;
		msg_cnt = 0;
		pc = 0;
		seq_result = SR_OK;
		cmd_status = ST_OK;
		scl_drv = 1'b1;
		sda_drv = 1'b1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_basic_messages();
		test_busy_reject();
		test_nack_paths();
		test_stretch_timeout();
		test_slow_bit_rate();
		test_result_backpressure();
		test_random_traffic();
		wait_drained();
		if (errors == 0 && expected_results.size() == 0) begin
			$display("** i2c_bitbang_master: PASSED **");
		end else begin
			$display("** i2c_bitbang_master: FAILED **");
		end
		$finish;
	end

endmodule
